FILE: sv/padf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padf_pkg
// Shared types and constants for the process identifier allow/deny filter.
// ----------------------------------------------------------------------------
package padf_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int PID_W       = 22;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	typedef enum logic [2:0] {
		MODE_CHECK       = 3'd0,
		MODE_ADD_EXCL    = 3'd1,
		MODE_ADD_INCL    = 3'd2,
		MODE_STOP        = 3'd3,
		MODE_CONTINUE    = 3'd4,
		MODE_CLEAR       = 3'd5,
		MODE_DELETE_EXCL = 3'd6,
		MODE_DELETE_INCL = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_FULL      = 2'd2
	} status_t;

	typedef logic [PID_W-1:0] pid_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

endpackage

FILE: sv/padf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padf_req_if / padf_rsp_if
// Valid/ready channels for request items and result items of the filter.
// ----------------------------------------------------------------------------
interface padf_req_if;
	import padf_pkg::*;

	logic  valid;
	logic  ready;
	mode_t mode;
	pid_t  pid;

	modport source (output valid, output mode, output pid, input ready);
	modport sink   (input valid, input mode, input pid, output ready);
endinterface

interface padf_rsp_if;
	import padf_pkg::*;

	logic    valid;
	logic    ready;
	logic    log_enable;
	status_t status;

	modport source (output valid, output log_enable, output status, input ready);
	modport sink   (input valid, input log_enable, input status, output ready);
endinterface

FILE: sv/pid_allow_deny_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_allow_deny_filter
// Include/exclude tables of process identifiers with a sequential search.
// ----------------------------------------------------------------------------
// One item is taken at a time. A check, add or delete item walks its table with a
// single shared identifier comparator, one slot per cycle, and stops at the first
// slot that answers; the item is accepted, scans one to TABLE_DEPTH slots and then
// loads the result register. Stop, continue and clear items, and checks that need
// no table, skip the scan and go straight from acceptance to the result register.
// The block is ready for a new item once the previous result has been loaded, even
// while that result still waits to be taken. Both tables are empty after reset,
// with no clearing pass.
module pid_allow_deny_filter (
	input logic         clk,
	input logic         arst_n,
	padf_req_if.sink    req,
	padf_rsp_if.source  rsp
);
	import padf_pkg::*;

	state_t            state_q;
	mode_t             mode_q;
	pid_t              pid_q;
	logic              sel_incl_q;
	logic [IDX_W-1:0]  idx_q;
	logic              res_log_q;
	status_t           res_status_q;

	pid_t              excl_ids_q [TABLE_DEPTH];
	pid_t              incl_ids_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] excl_valid_q;
	logic [TABLE_DEPTH-1:0] incl_valid_q;
	logic              excl_active_q;
	logic              incl_active_q;
	logic              stopped_q;

	logic              out_valid_q;
	logic              out_log_q;
	status_t           out_status_q;

	pid_t              cur_id;
	logic              cur_valid;
	logic              is_add;
	logic              slot_hit;
	logic              last_slot;
	logic              accept;
	logic              id_write;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);

	// The one comparator of the block looks at the selected table's current slot.
	assign cur_id    = sel_incl_q ? incl_ids_q[idx_q] : excl_ids_q[idx_q];
	assign cur_valid = sel_incl_q ? incl_valid_q[idx_q] : excl_valid_q[idx_q];
	assign is_add    = (mode_q == MODE_ADD_EXCL) || (mode_q == MODE_ADD_INCL);
	assign slot_hit  = is_add ? !cur_valid : (cur_valid && (cur_id == pid_q));
	assign last_slot = (idx_q == IDX_W'(TABLE_DEPTH - 1));
	assign id_write  = (state_q == ST_SCAN) && slot_hit && is_add;

	always_ff @(posedge clk) begin
		if (id_write) begin
			if (sel_incl_q) begin
				incl_ids_q[idx_q] <= pid_q;
			end else begin
				excl_ids_q[idx_q] <= pid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req.mode;
			pid_q  <= req.pid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			sel_incl_q    <= 1'b0;
			idx_q         <= '0;
			res_log_q     <= 1'b0;
			res_status_q  <= STATUS_OK;
			excl_valid_q  <= '0;
			incl_valid_q  <= '0;
			excl_active_q <= 1'b0;
			incl_active_q <= 1'b0;
			stopped_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q        <= '0;
						res_log_q    <= 1'b0;
						res_status_q <= STATUS_OK;
						state_q      <= ST_OUT;
						case (req.mode)
							MODE_CHECK: begin
								if (stopped_q) begin
									res_log_q <= 1'b0;
								end else if (incl_active_q) begin
									sel_incl_q <= 1'b1;
									state_q    <= ST_SCAN;
								end else if (excl_active_q) begin
									sel_incl_q <= 1'b0;
									state_q    <= ST_SCAN;
								end else begin
									res_log_q <= 1'b1;
								end
							end
							MODE_ADD_EXCL, MODE_DELETE_EXCL: begin
								sel_incl_q <= 1'b0;
								state_q    <= ST_SCAN;
							end
							MODE_ADD_INCL, MODE_DELETE_INCL: begin
								sel_incl_q <= 1'b1;
								state_q    <= ST_SCAN;
							end
							MODE_STOP: begin
								stopped_q <= 1'b1;
							end
							MODE_CONTINUE: begin
								stopped_q <= 1'b0;
							end
							MODE_CLEAR: begin
								stopped_q     <= 1'b0;
								excl_valid_q  <= '0;
								incl_valid_q  <= '0;
								excl_active_q <= 1'b0;
								incl_active_q <= 1'b0;
							end
							default: begin
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (slot_hit) begin
						state_q <= ST_OUT;
						case (mode_q)
							MODE_CHECK: begin
								// A listed identifier is logged only under the include table.
								res_log_q <= sel_incl_q;
							end
							MODE_ADD_EXCL: begin
								excl_valid_q[idx_q] <= 1'b1;
								excl_active_q       <= 1'b1;
							end
							MODE_ADD_INCL: begin
								incl_valid_q[idx_q] <= 1'b1;
								incl_active_q       <= 1'b1;
							end
							MODE_DELETE_EXCL: begin
								excl_valid_q[idx_q] <= 1'b0;
							end
							MODE_DELETE_INCL: begin
								incl_valid_q[idx_q] <= 1'b0;
							end
							default: begin
								res_status_q <= STATUS_OK;
							end
						endcase
					end else if (last_slot) begin
						state_q <= ST_OUT;
						case (mode_q)
							MODE_CHECK: begin
								res_log_q <= !sel_incl_q;
							end
							MODE_ADD_EXCL, MODE_ADD_INCL: begin
								res_status_q <= STATUS_FULL;
							end
							MODE_DELETE_EXCL, MODE_DELETE_INCL: begin
								res_status_q <= STATUS_NOT_FOUND;
							end
							default: begin
								res_status_q <= STATUS_OK;
							end
						endcase
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_OUT: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register: a finished item waits here while the next one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && (!out_valid_q || rsp.ready)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && (!out_valid_q || rsp.ready)) begin
			out_log_q    <= res_log_q;
			out_status_q <= res_status_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.log_enable = out_log_q;
	assign rsp.status     = out_status_q;

endmodule

FILE: sv/padf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padf_checker
// Port-level assertions for the filter, bound to the top level.
// ----------------------------------------------------------------------------
module padf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       log_enable,
	input logic [1:0] status
);
	import padf_pkg::*;

	// Only one item is in work at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("filter ready in the cycle after taking an item");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
		(rsp_valid && $stable(status) && $stable(log_enable)))
		else $error("stalled result changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == STATUS_OK || status == STATUS_NOT_FOUND ||
		status == STATUS_FULL))
		else $error("undefined status code");

	// A failed command never asks for logging.
	a_no_log_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != STATUS_OK) |-> !log_enable)
		else $error("log enable set on a failed command");

endmodule

bind pid_allow_deny_filter padf_checker u_padf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.log_enable (rsp.log_enable),
	.status     (rsp.status)
);
